// File: design/ata_pio_disk_device_defines.svh
// Assertion macros used by the checks in ata_pio_disk_device.
`ifndef ATA_PIO_DISK_DEVICE_DEFINES_SVH
`define ATA_PIO_DISK_DEVICE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ATA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ata_pio_pkg.sv
package ata_pio_pkg;

  localparam int MaxCylindersDef = 4;
  localparam int SectorWords     = 256;
  localparam int IdxW            = 37;
  localparam int CylWordsLog2    = 18;

  // Bus actions.
  localparam logic [1:0] ActByteRd = 2'd0;
  localparam logic [1:0] ActWordRd = 2'd1;
  localparam logic [1:0] ActByteWr = 2'd2;
  localparam logic [1:0] ActWordWr = 2'd3;

  // Register offsets.
  localparam logic [8:0] OffData    = 9'h000;
  localparam logic [8:0] OffError   = 9'h001;
  localparam logic [8:0] OffSecCnt  = 9'h002;
  localparam logic [8:0] OffSecNum  = 9'h003;
  localparam logic [8:0] OffCylLow  = 9'h004;
  localparam logic [8:0] OffCylHigh = 9'h005;
  localparam logic [8:0] OffDrvHead = 9'h006;
  localparam logic [8:0] OffCmdStat = 9'h007;
  localparam logic [8:0] OffDevCtl  = 9'h100;

  // Commands.
  localparam logic [7:0] CmdIdentify = 8'hEC;
  localparam logic [7:0] CmdInitParm = 8'h91;
  localparam logic [7:0] CmdRead     = 8'h20;
  localparam logic [7:0] CmdReadNr   = 8'h21;
  localparam logic [7:0] CmdWrite    = 8'h30;
  localparam logic [7:0] CmdWriteNr  = 8'h31;
  localparam logic [7:0] CmdReadMul  = 8'hC4;
  localparam logic [7:0] CmdWriteMul = 8'hC5;

  // Status and device control bits.
  localparam logic [7:0] StBsy  = 8'h80;
  localparam logic [7:0] StDrdy = 8'h40;
  localparam logic [7:0] StDsc  = 8'h10;
  localparam logic [7:0] StDrq  = 8'h08;
  localparam int DcRstBit  = 2;
  localparam int DcNienBit = 1;

  // Result of the task file stage for one beat.
  typedef struct packed {
    logic [15:0] rdata;
    logic        use_mem;
    logic        raise_irq;
    logic        clear_irq;
  } stage_t;

  // Identify word for a word index, already byte-swapped.
  function automatic logic [15:0] ident_word(input logic [7:0] idx, input logic [2:0] cyl);
    logic [15:0] w;
    logic [12:0] total;
    total = {cyl, 10'b0};
    w = 16'h0000;
    if (idx >= 8'd32 && idx <= 8'd46) begin
      w = 16'h2020;
    end else begin
      case (idx)
        8'd0:                         w = 16'h0444;
        8'd1, 8'd54:                  w = {13'b0, cyl};
        8'd3, 8'd55:                  w = 16'd16;
        8'd4:                         w = 16'h8000;
        8'd5, 8'd21:                  w = 16'h0200;
        8'd6, 8'd56:                  w = 16'd64;
        8'd20:                        w = 16'd3;
        8'd22:                        w = 16'd4;
        8'd27:                        w = 16'h6f72;
        8'd28:                        w = 16'h656d;
        8'd29:                        w = 16'h752d;
        8'd30:                        w = 16'h6469;
        8'd31:                        w = 16'h736b;
        8'd47:                        w = 16'h8100;
        8'd49, 8'd51, 8'd52:          w = 16'h0200;
        8'd57, 8'd60:                 w = {3'b0, total};
        8'd59:                        w = 16'h0100;
        8'd80:                        w = 16'd6;
        8'd82, 8'd83, 8'd84, 8'd85,
        8'd87:                        w = 16'h4000;
        default:                      w = 16'h0000;
      endcase
    end
    return {w[7:0], w[15:8]};
  endfunction

endpackage

// File: design/ata_pio_sector_ram.sv
module ata_pio_sector_ram #(
  parameter int Depth = 1048576,
  parameter int AddrW = 20
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [15:0]      wdata_i,
  output logic [15:0]      rdata_o
);

  logic [15:0] mem [Depth];
  logic [15:0] rdata_q;

  // Single port: write or registered read at one address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ata_pio_taskfile.sv
module ata_pio_taskfile #(
  parameter int MaxCylinders = 4,
  parameter int AddrW = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [1:0]           action_i,
  input  logic [8:0]           offset_i,
  input  logic [15:0]          wdata_i,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_wdata_i,
  output ata_pio_pkg::stage_t  stage_o,
  output logic                 mem_we_o,
  output logic                 mem_re_o,
  output logic [AddrW-1:0]     mem_addr_o
);
  import ata_pio_pkg::*;

  logic [2:0]      cyl_cnt_q;
  logic [7:0]      dev_ctl_q, dev_ctl_d, drv_head_q, drv_head_d;
  logic [7:0]      sec_num_q, sec_num_d, sec_cnt_q, sec_cnt_d;
  logic [7:0]      status_q, status_d, feature_q, feature_d;
  logic [7:0]      error_q, error_d, command_q, command_d;
  logic [7:0]      cyl_low_q, cyl_low_d, cyl_high_q, cyl_high_d;
  logic            selected_q, selected_d, from_ident_q, from_ident_d;
  logic [IdxW-1:0] widx_q, widx_d, send_q, send_d;

  logic [2:0]      cyls;
  logic [IdxW-1:0] buf_size, widx_inc;
  logic [27:0]     sector, sector_inc;
  logic            in_range, irq_on;
  logic [7:0]      b;
  logic [8:0]      n_sec;
  stage_t          st;

  // Effective cylinder count and buffer size.
  always_comb begin
    cyls = ({29'b0, cyl_cnt_q} > MaxCylinders) ? 3'(MaxCylinders) : cyl_cnt_q;
    buf_size = from_ident_q ? IdxW'(SectorWords)
                            : IdxW'({cyls, {CylWordsLog2{1'b0}}});
  end

  assign sector     = drv_head_q[6] ? {drv_head_q[3:0], cyl_high_q, cyl_low_q, sec_num_q} : '0;
  assign sector_inc = sector + 28'd1;
  assign in_range   = (offset_i == OffData) && (widx_q < buf_size);
  assign widx_inc   = widx_q + IdxW'(1);
  assign irq_on     = !dev_ctl_q[DcNienBit];
  assign b          = wdata_i[7:0];
  assign n_sec      = (sec_cnt_q == 8'd0) ? 9'd256 : {1'b0, sec_cnt_q};

  // Next state and result of one beat.
  always_comb begin
    dev_ctl_d = dev_ctl_q;    drv_head_d = drv_head_q;
    sec_num_d = sec_num_q;    sec_cnt_d = sec_cnt_q;
    status_d = status_q;      feature_d = feature_q;
    error_d = error_q;        command_d = command_q;
    cyl_low_d = cyl_low_q;    cyl_high_d = cyl_high_q;
    selected_d = selected_q;  from_ident_d = from_ident_q;
    widx_d = widx_q;          send_d = send_q;
    st = '0;
    mem_we_o = 1'b0;
    mem_re_o = 1'b0;
    case (action_i)
      ActByteRd: begin
        if (!selected_q) begin
          st.rdata = 16'h00ff;
        end else begin
          case (offset_i)
            OffError:   st.rdata = {8'b0, error_q};
            OffSecCnt:  st.rdata = {8'b0, sec_cnt_q};
            OffSecNum:  st.rdata = {8'b0, sec_num_q};
            OffCylLow:  st.rdata = {8'b0, cyl_low_q};
            OffCylHigh: st.rdata = {8'b0, cyl_high_q};
            OffDrvHead: st.rdata = {8'b0, drv_head_q};
            OffCmdStat: begin
              st.rdata = {8'b0, status_q};
              st.clear_irq = 1'b1;
            end
            OffDevCtl:  st.rdata = {8'b0, status_q};
            default:    st.rdata = 16'h0000;
          endcase
        end
      end
      ActWordRd, ActWordWr: begin
        if (in_range) begin
          if (action_i == ActWordRd) begin
            if (from_ident_q) begin
              st.rdata = ident_word(widx_q[7:0], cyls);
            end else begin
              st.use_mem = 1'b1;
              mem_re_o = 1'b1;
            end
          end else begin
            mem_we_o = !from_ident_q;
          end
          widx_d = widx_inc;
          if (widx_inc >= send_q) begin
            status_d = StDrdy | StDsc;
            if (action_i == ActWordWr) begin
              st.raise_irq = irq_on;
            end
            // Multi-sector single commands move on to the next sector.
            if (((action_i == ActWordRd && command_q == CmdRead) ||
                 (action_i == ActWordWr && command_q == CmdWrite)) && sec_cnt_q != 8'd1) begin
              sec_cnt_d = sec_cnt_q - 8'd1;
              sec_num_d = sector_inc[7:0];
              cyl_low_d = sector_inc[15:8];
              cyl_high_d = sector_inc[23:16];
              drv_head_d = {drv_head_q[7:4], sector_inc[27:24]};
              send_d = send_q + IdxW'(SectorWords);
              status_d = StDrdy | StDsc | StDrq;
              if (action_i == ActWordRd) begin
                st.raise_irq = irq_on;
              end
            end
          end
        end
      end
      default: begin
        if (offset_i == OffDrvHead) begin
          drv_head_d = b;
          selected_d = !b[4];
        end else if (offset_i == OffDevCtl) begin
          // Soft reset falls on the release of SRST.
          if (!b[DcRstBit] && dev_ctl_q[DcRstBit]) begin
            drv_head_d = {drv_head_q[7:4], 4'b0};
            status_d = StDrdy | StDsc;
            sec_num_d = 8'd1;
            sec_cnt_d = 8'd1;
            cyl_low_d = 8'd0;
            cyl_high_d = 8'd0;
            error_d = 8'd1;
            command_d = 8'd0;
          end else if (b[DcRstBit] && !dev_ctl_q[DcRstBit]) begin
            error_d = 8'd1;
            status_d = StBsy | StDsc;
          end
          dev_ctl_d = b;
        end else if (selected_q) begin
          case (offset_i)
            OffError:   feature_d = b;
            OffSecCnt:  sec_cnt_d = b;
            OffSecNum:  sec_num_d = b;
            OffCylLow:  cyl_low_d = b;
            OffCylHigh: cyl_high_d = b;
            OffCmdStat: begin
              command_d = b;
              case (b)
                CmdIdentify: begin
                  from_ident_d = 1'b1;
                  widx_d = '0;
                  send_d = IdxW'(SectorWords);
                  status_d = StDrdy | StDsc | StDrq;
                  st.raise_irq = irq_on;
                end
                CmdInitParm: begin
                  status_d = StDrdy | StDsc;
                  error_d = 8'd0;
                  st.raise_irq = irq_on;
                end
                CmdRead, CmdReadNr, CmdWrite, CmdWriteNr, CmdReadMul, CmdWriteMul: begin
                  from_ident_d = 1'b0;
                  widx_d = IdxW'({sector, 8'b0});
                  if (b == CmdReadMul || b == CmdWriteMul) begin
                    send_d = IdxW'({sector, 8'b0}) + IdxW'({n_sec, 8'b0});
                  end else begin
                    send_d = IdxW'({sector, 8'b0}) + IdxW'(SectorWords);
                  end
                  status_d = StDrdy | StDsc | StDrq;
                  error_d = 8'd0;
                  st.raise_irq = (b == CmdRead || b == CmdReadNr || b == CmdReadMul) && irq_on;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
    endcase
    mem_we_o = mem_we_o && accept_i;
    mem_re_o = mem_re_o && accept_i;
  end

  assign stage_o    = st;
  assign mem_addr_o = widx_q[AddrW-1:0];

  // Task file registers, updated on each accepted beat; the cylinder count on cfg_we_i.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyl_cnt_q <= '0;
      dev_ctl_q <= 8'h08;  drv_head_q <= 8'ha0;
      sec_num_q <= 8'h01;  sec_cnt_q <= 8'h01;
      status_q <= StDrdy;  feature_q <= '0;
      error_q <= 8'h01;    command_q <= '0;
      cyl_low_q <= '0;     cyl_high_q <= '0;
      selected_q <= 1'b1;  from_ident_q <= 1'b1;
      widx_q <= '0;        send_q <= IdxW'(SectorWords);
    end else begin
      if (cfg_we_i) begin
        cyl_cnt_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        dev_ctl_q <= dev_ctl_d;    drv_head_q <= drv_head_d;
        sec_num_q <= sec_num_d;    sec_cnt_q <= sec_cnt_d;
        status_q <= status_d;      feature_q <= feature_d;
        error_q <= error_d;        command_q <= command_d;
        cyl_low_q <= cyl_low_d;    cyl_high_q <= cyl_high_d;
        selected_q <= selected_d;  from_ident_q <= from_ident_d;
        widx_q <= widx_d;          send_q <= send_d;
      end
    end
  end

endmodule

// File: design/ata_pio_disk_device.sv
// Channel  | Handshake                 | Payload
// -------- | ------------------------- | ------------------------------------
// in       | in_valid_i / in_stall_o   | action_i, offset_i, wdata_i
// out      | out_valid_o / out_stall_i | rdata_o, raise_irq_o, clear_irq_o
// cfg      | cfg_we_i                  | cfg_wdata_i (cylinder count)
// One beat is accepted per cycle unless stage and output registers are both full under
// output stall. The stage register and the sector memory's registered read fill at the
// accepting edge; the output register takes the result when it advances. Reset sets the
// task file to defaults, not the sector store; the user must read that only after it has
// been written, which the block does not enforce. Output stall holds the output register.
module ata_pio_disk_device #(
  parameter int MAX_CYLINDERS = ata_pio_pkg::MaxCylindersDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [8:0]  offset_i,
  input  logic [15:0] wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] rdata_o,
  output logic        raise_irq_o,
  output logic        clear_irq_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i
);
  import ata_pio_pkg::*;
  `include "ata_pio_disk_device_defines.svh"

  localparam int Depth = MAX_CYLINDERS * (1 << CylWordsLog2);
  localparam int AddrW = $clog2(Depth);

  stage_t             stage, s1_q;
  logic               s1_valid_q, out_valid_q, advance, accept;
  logic               mem_we, mem_re;
  logic [AddrW-1:0]   mem_addr;
  logic [15:0]        mem_rdata, rdata_q;
  logic               raise_q, clear_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  ata_pio_taskfile #(.MaxCylinders(MAX_CYLINDERS), .AddrW(AddrW)) u_taskfile (
    .clk_i, .rst_ni,
    .accept_i(accept), .action_i, .offset_i, .wdata_i,
    .cfg_we_i, .cfg_wdata_i,
    .stage_o(stage), .mem_we_o(mem_we), .mem_re_o(mem_re), .mem_addr_o(mem_addr)
  );

  ata_pio_sector_ram #(.Depth(Depth), .AddrW(AddrW)) u_ram (
    .clk_i, .we_i(mem_we), .re_i(mem_re), .addr_i(mem_addr),
    .wdata_i, .rdata_o(mem_rdata)
  );

  // Stage register and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      s1_valid_q <= accept || (s1_valid_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= stage;
    end
    if (advance && s1_valid_q) begin
      rdata_q <= s1_q.use_mem ? mem_rdata : s1_q.rdata;
      raise_q <= s1_q.raise_irq;
      clear_q <= s1_q.clear_irq;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rdata_o     = rdata_q;
  assign raise_irq_o = raise_q;
  assign clear_irq_o = clear_q;

  `ATA_ASSERT_NOW(a_irq_excl, clk_i, rst_ni, out_valid_q, !(raise_q && clear_q), "raise and clear together")
  `ATA_ASSERT_NOW(a_stall_src, clk_i, rst_ni, in_stall_o, s1_valid_q && out_valid_q, "stall without full pipe")
  `ATA_ASSERT_NEXT(a_mem_zero, clk_i, rst_ni, accept && mem_re, s1_q.rdata == 16'h0000, "memory beat carries data")

endmodule
